@@ rtl/core/cbc_pkg.sv @@
// shared types, constants and helper functions for the circle boundary collision block
// no dependencies
`default_nettype none

package cbc_pkg;

  localparam int unsigned BallRadiusPx = 3;
  localparam int unsigned SqrtSteps    = 16;
  localparam int unsigned Div1Steps    = 9;
  localparam int unsigned Div2Steps    = 11;
  localparam int unsigned BounceStages = 6;

  localparam logic [8:0]  CenterXRst = 9'd72;
  localparam logic [8:0]  CenterYRst = 9'd72;
  localparam logic [8:0]  RadiusRst  = 9'd72;
  localparam logic [10:0] BounceRst  = 11'd307;
  localparam logic [11:0] OneQ10     = 12'd1024;

  typedef enum logic [1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegRadius  = 2'd2,
    RegBounce  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic               hit;
  } ball_t;

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [24:0] rem_x;
    logic [24:0] rem_y;
    logic [10:0] q_x;
    logic [10:0] q_y;
    logic [15:0] den;
    logic        neg_x;
    logic        neg_y;
  } div_t;

  // signed divide by 1024, truncating toward zero
  function automatic logic signed [49:0] trunc_q10(input logic signed [49:0] x);
    logic signed [49:0] adj;
    adj = x[49] ? (x + 50'sd1023) : x;
    return adj >>> 10;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
    logic signed [31:0] r;
    if (x > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cbc_sqrt_cell.sv @@
// one digit step of the pipelined integer square root
// depends on cbc_pkg
`default_nettype none

module cbc_sqrt_cell #(
  parameter int unsigned BitPos = 30
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire cbc_pkg::sqrt_t sq_i,
  input  wire cbc_pkg::ball_t ball_i,
  output logic               valid_o,
  output cbc_pkg::sqrt_t     sq_o,
  output cbc_pkg::ball_t     ball_o
);

  localparam logic [31:0] Bit = 32'd1 << BitPos;

  logic [32:0]    trial;
  cbc_pkg::sqrt_t sq_d;
  logic           valid_q;
  cbc_pkg::sqrt_t sq_q;
  cbc_pkg::ball_t ball_q;

  always_comb begin
    trial = {1'b0, sq_i.res} + {1'b0, Bit};
    sq_d  = sq_i;
    if ({1'b0, sq_i.n} >= trial) begin
      sq_d.n   = sq_i.n - trial[31:0];
      sq_d.res = (sq_i.res >> 1) + Bit;
    end else begin
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    ball_q <= ball_i;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign ball_o  = ball_q;

endmodule

`default_nettype wire

@@ rtl/core/cbc_div_cell.sv @@
// one quotient bit of the pipelined two-lane restoring divider
// depends on cbc_pkg
`default_nettype none

module cbc_div_cell #(
  parameter int unsigned BitPos = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire cbc_pkg::div_t  dv_i,
  input  wire cbc_pkg::ball_t ball_i,
  output logic                valid_o,
  output cbc_pkg::div_t       dv_o,
  output cbc_pkg::ball_t      ball_o
);

  logic [26:0]    dsh;
  cbc_pkg::div_t  dv_d;
  logic           valid_q;
  cbc_pkg::div_t  dv_q;
  cbc_pkg::ball_t ball_q;

  always_comb begin
    dsh  = 27'(dv_i.den) << BitPos;
    dv_d = dv_i;
    if ({2'b0, dv_i.rem_x} >= dsh) begin
      dv_d.rem_x       = dv_i.rem_x - dsh[24:0];
      dv_d.q_x[BitPos] = 1'b1;
    end
    if ({2'b0, dv_i.rem_y} >= dsh) begin
      dv_d.rem_y       = dv_i.rem_y - dsh[24:0];
      dv_d.q_y[BitPos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q   <= dv_d;
    ball_q <= ball_i;
  end

  assign valid_o = valid_q;
  assign dv_o    = dv_q;
  assign ball_o  = ball_q;

endmodule

`default_nettype wire

@@ rtl/core/cbc_bounce.sv @@
// velocity response pipeline: normal speed, restitution scale and reflection
// depends on cbc_pkg
`default_nettype none

module cbc_bounce (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire cbc_pkg::ball_t     ball_i,
  input  wire logic signed [11:0] nx_i,
  input  wire logic signed [11:0] ny_i,
  input  wire logic [10:0]        bounce_i,
  output logic                    valid_o,
  output cbc_pkg::ball_t          ball_o
);

  logic [5:0] valid_q;

  cbc_pkg::ball_t     b1_q, b2_q, b3_q, b4_q, b5_q, b6_q;
  cbc_pkg::ball_t     b6_d;
  logic signed [11:0] nx1_q, ny1_q, nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic signed [43:0] px1_q, py1_q;
  logic signed [34:0] nv2_q;
  logic               ap2_q, ap3_q, ap4_q, ap5_q;
  logic signed [47:0] sp3_q;
  logic signed [37:0] sc4_q;
  logic signed [49:0] sx5_q, sy5_q;

  logic signed [44:0] sum_v;
  logic signed [49:0] nv_w;
  logic signed [12:0] gain;
  logic signed [49:0] sc_w;
  logic signed [49:0] dx_w, dy_w;
  logic signed [40:0] vx_w, vy_w;

  always_comb begin
    sum_v = 45'(px1_q) + 45'(py1_q);
    nv_w  = cbc_pkg::trunc_q10(50'(sum_v));
    gain  = $signed({1'b0, cbc_pkg::OneQ10 + 12'(bounce_i)});
    sc_w  = cbc_pkg::trunc_q10(50'(sp3_q));
    dx_w  = cbc_pkg::trunc_q10(sx5_q);
    dy_w  = cbc_pkg::trunc_q10(sy5_q);
    vx_w  = 41'(b5_q.vel_x) - 41'(dx_w);
    vy_w  = 41'(b5_q.vel_y) - 41'(dy_w);
    b6_d  = b5_q;
    if (ap5_q) begin
      b6_d.vel_x = cbc_pkg::sat32(vx_w);
      b6_d.vel_y = cbc_pkg::sat32(vy_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q  <= ball_i;
    nx1_q <= nx_i;
    ny1_q <= ny_i;
    px1_q <= ball_i.vel_x * nx_i;
    py1_q <= ball_i.vel_y * ny_i;

    b2_q  <= b1_q;
    nx2_q <= nx1_q;
    ny2_q <= ny1_q;
    nv2_q <= nv_w[34:0];
    ap2_q <= b1_q.hit && (nv_w > 50'sd0);

    b3_q  <= b2_q;
    nx3_q <= nx2_q;
    ny3_q <= ny2_q;
    ap3_q <= ap2_q;
    sp3_q <= nv2_q * gain;

    b4_q  <= b3_q;
    nx4_q <= nx3_q;
    ny4_q <= ny3_q;
    ap4_q <= ap3_q;
    sc4_q <= sc_w[37:0];

    b5_q  <= b4_q;
    ap5_q <= ap4_q;
    sx5_q <= sc4_q * nx4_q;
    sy5_q <= sc4_q * ny4_q;

    b6_q <= b6_d;
  end

  assign valid_o = valid_q[5];
  assign ball_o  = b6_q;

endmodule

`default_nettype wire

@@ rtl/core/circle_boundary_collision.sv @@
// top level of the circle boundary collision block: config registers, front end and cell rows
// depends on cbc_pkg, cbc_sqrt_cell, cbc_div_cell, cbc_bounce
//
// channel   direction  handshake               payload
// ball in   input      start_i, busy_o         pos_x_i pos_y_i vel_x_i vel_y_i
// result    output     done_o (strobe)         new_pos_x_o new_pos_y_o new_vel_x_o new_vel_y_o
//                                              hit_border_o
// config    input      cfg_we_i                cfg_idx_i cfg_data_i
//
// one beat is taken every cycle; busy_o stays low
// each beat passes through three front stages, 16 square root
// cells, two divider rows of 9 and 11 cells with a stage each, six velocity stages
// reset clears all valid bits and loads the register defaults
// the receiver cannot stall, so there is no back pressure anywhere
`default_nettype none

module circle_boundary_collision #(
  parameter int unsigned BallRadiusPx = cbc_pkg::BallRadiusPx
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  output logic                    done_o,
  output logic signed [31:0]      new_pos_x_o,
  output logic signed [31:0]      new_pos_y_o,
  output logic signed [31:0]      new_vel_x_o,
  output logic signed [31:0]      new_vel_y_o,
  output logic                    hit_border_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [10:0]        cfg_data_i
);

  localparam int unsigned Latency = 3 + cbc_pkg::SqrtSteps + 1 + cbc_pkg::Div1Steps + 1
                                  + cbc_pkg::Div2Steps + cbc_pkg::BounceStages;

  logic [8:0]  center_x_q, center_y_q, radius_q;
  logic [10:0] bounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= cbc_pkg::CenterXRst;
      center_y_q <= cbc_pkg::CenterYRst;
      radius_q   <= cbc_pkg::RadiusRst;
      bounce_q   <= cbc_pkg::BounceRst;
    end else if (cfg_we_i) begin
      case (cbc_pkg::reg_idx_e'(cfg_idx_i))
        cbc_pkg::RegCenterX: center_x_q <= cfg_data_i[8:0];
        cbc_pkg::RegCenterY: center_y_q <= cfg_data_i[8:0];
        cbc_pkg::RegRadius:  radius_q   <= cfg_data_i[8:0];
        cbc_pkg::RegBounce:  bounce_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic       r_ok;
  logic [8:0] r_w;
  assign r_ok = radius_q > 9'(BallRadiusPx);
  assign r_w  = radius_q - 9'(BallRadiusPx);

  logic acc;
  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  // front end: offsets, squares, distance compare
  logic           v0_q, v1_q, v2_q;
  cbc_pkg::ball_t b0_d, b0_q, b1_q, b2_d, b2_q;
  logic [31:0]    sqx1_q, sqy1_q, dsq2_q;
  logic [17:0]    rr1_q;
  logic signed [35:0] sqx_w, sqy_w;
  logic [31:0]    dsq_w;

  always_comb begin
    b0_d.pos_x = pos_x_i;
    b0_d.pos_y = pos_y_i;
    b0_d.vel_x = vel_x_i;
    b0_d.vel_y = vel_y_i;
    b0_d.rx    = 18'($signed(pos_x_i[31:16])) - $signed({9'b0, center_x_q});
    b0_d.ry    = 18'($signed(pos_y_i[31:16])) - $signed({9'b0, center_y_q});
    b0_d.hit   = r_ok;
    sqx_w      = b0_q.rx * b0_q.rx;
    sqy_w      = b0_q.ry * b0_q.ry;
    dsq_w      = sqx1_q + sqy1_q;
    b2_d       = b1_q;
    b2_d.hit   = b1_q.hit && ({14'b0, rr1_q} < dsq_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= acc;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q   <= b0_d;
    b1_q   <= b0_q;
    sqx1_q <= sqx_w[31:0];
    sqy1_q <= sqy_w[31:0];
    rr1_q  <= r_w * r_w;
    b2_q   <= b2_d;
    dsq2_q <= dsq_w;
  end

  // square root cell row
  logic           sv [cbc_pkg::SqrtSteps+1];
  cbc_pkg::sqrt_t sq [cbc_pkg::SqrtSteps+1];
  cbc_pkg::ball_t sb [cbc_pkg::SqrtSteps+1];

  assign sv[0]     = v2_q;
  assign sq[0].n   = dsq2_q;
  assign sq[0].res = '0;
  assign sb[0]     = b2_q;

  for (genvar k = 0; k < cbc_pkg::SqrtSteps; k++) begin : g_sqrt
    cbc_sqrt_cell #(.BitPos(30 - 2 * k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[k]),
      .sq_i    (sq[k]),
      .ball_i  (sb[k]),
      .valid_o (sv[k+1]),
      .sq_o    (sq[k+1]),
      .ball_o  (sb[k+1])
    );
  end

  // dividend |rel| * r for the projection
  logic           vp_q;
  cbc_pkg::div_t  dp_d, dp_q;
  cbc_pkg::ball_t bp_d, bp_q;
  logic [17:0]    ax_w, ay_w;
  logic [26:0]    mx_w, my_w;
  logic [15:0]    d_w;

  always_comb begin
    d_w      = sq[cbc_pkg::SqrtSteps].res[15:0];
    ax_w     = sb[cbc_pkg::SqrtSteps].rx[17] ? 18'(-sb[cbc_pkg::SqrtSteps].rx)
                                              : sb[cbc_pkg::SqrtSteps].rx;
    ay_w     = sb[cbc_pkg::SqrtSteps].ry[17] ? 18'(-sb[cbc_pkg::SqrtSteps].ry)
                                              : sb[cbc_pkg::SqrtSteps].ry;
    mx_w     = ax_w * r_w;
    my_w     = ay_w * r_w;
    dp_d.rem_x = mx_w[24:0];
    dp_d.rem_y = my_w[24:0];
    dp_d.q_x   = '0;
    dp_d.q_y   = '0;
    dp_d.den   = d_w;
    dp_d.neg_x = sb[cbc_pkg::SqrtSteps].rx[17];
    dp_d.neg_y = sb[cbc_pkg::SqrtSteps].ry[17];
    bp_d       = sb[cbc_pkg::SqrtSteps];
    bp_d.hit   = sb[cbc_pkg::SqrtSteps].hit && (d_w != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= sv[cbc_pkg::SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q <= dp_d;
    bp_q <= bp_d;
  end

  // first divider row: rel * r / d
  logic           av [cbc_pkg::Div1Steps+1];
  cbc_pkg::div_t  ad [cbc_pkg::Div1Steps+1];
  cbc_pkg::ball_t ab [cbc_pkg::Div1Steps+1];

  assign av[0] = vp_q;
  assign ad[0] = dp_q;
  assign ab[0] = bp_q;

  for (genvar k = 0; k < cbc_pkg::Div1Steps; k++) begin : g_div1
    cbc_div_cell #(.BitPos(cbc_pkg::Div1Steps - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (av[k]),
      .dv_i    (ad[k]),
      .ball_i  (ab[k]),
      .valid_o (av[k+1]),
      .dv_o    (ad[k+1]),
      .ball_o  (ab[k+1])
    );
  end

  // projected position and dividend for the normal
  logic           vn_q;
  cbc_pkg::div_t  dn_d, dn_q;
  cbc_pkg::ball_t bn_d, bn_q;
  logic [8:0]     qx_w, qy_w;
  logic signed [11:0] px_w, py_w;

  always_comb begin
    qx_w = ad[cbc_pkg::Div1Steps].q_x[8:0];
    qy_w = ad[cbc_pkg::Div1Steps].q_y[8:0];
    px_w = $signed({3'b0, center_x_q}) + (ad[cbc_pkg::Div1Steps].neg_x
             ? -$signed({3'b0, qx_w}) : $signed({3'b0, qx_w}));
    py_w = $signed({3'b0, center_y_q}) + (ad[cbc_pkg::Div1Steps].neg_y
             ? -$signed({3'b0, qy_w}) : $signed({3'b0, qy_w}));
    bn_d = ab[cbc_pkg::Div1Steps];
    if (ab[cbc_pkg::Div1Steps].hit) begin
      bn_d.pos_x = {{4{px_w[11]}}, px_w, 16'b0};
      bn_d.pos_y = {{4{py_w[11]}}, py_w, 16'b0};
    end
    dn_d.rem_x = {6'b0, qx_w, 10'b0};
    dn_d.rem_y = {6'b0, qy_w, 10'b0};
    dn_d.q_x   = '0;
    dn_d.q_y   = '0;
    dn_d.den   = {7'b0, r_w};
    dn_d.neg_x = ad[cbc_pkg::Div1Steps].neg_x;
    dn_d.neg_y = ad[cbc_pkg::Div1Steps].neg_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else begin
      vn_q <= av[cbc_pkg::Div1Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    dn_q <= dn_d;
    bn_q <= bn_d;
  end

  // second divider row: rel' * 1024 / r
  logic           nv [cbc_pkg::Div2Steps+1];
  cbc_pkg::div_t  nd [cbc_pkg::Div2Steps+1];
  cbc_pkg::ball_t nb [cbc_pkg::Div2Steps+1];

  assign nv[0] = vn_q;
  assign nd[0] = dn_q;
  assign nb[0] = bn_q;

  for (genvar k = 0; k < cbc_pkg::Div2Steps; k++) begin : g_div2
    cbc_div_cell #(.BitPos(cbc_pkg::Div2Steps - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (nv[k]),
      .dv_i    (nd[k]),
      .ball_i  (nb[k]),
      .valid_o (nv[k+1]),
      .dv_o    (nd[k+1]),
      .ball_o  (nb[k+1])
    );
  end

  logic signed [11:0] nx_w, ny_w;
  assign nx_w = nd[cbc_pkg::Div2Steps].neg_x ? -$signed({1'b0, nd[cbc_pkg::Div2Steps].q_x})
                                             : $signed({1'b0, nd[cbc_pkg::Div2Steps].q_x});
  assign ny_w = nd[cbc_pkg::Div2Steps].neg_y ? -$signed({1'b0, nd[cbc_pkg::Div2Steps].q_y})
                                             : $signed({1'b0, nd[cbc_pkg::Div2Steps].q_y});

  cbc_pkg::ball_t res_w;

  cbc_bounce u_bounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (nv[cbc_pkg::Div2Steps]),
    .ball_i   (nb[cbc_pkg::Div2Steps]),
    .nx_i     (nx_w),
    .ny_i     (ny_w),
    .bounce_i (bounce_q),
    .valid_o  (done_o),
    .ball_o   (res_w)
  );

  assign new_pos_x_o  = res_w.pos_x;
  assign new_pos_y_o  = res_w.pos_y;
  assign new_vel_x_o  = res_w.vel_x;
  assign new_vel_y_o  = res_w.vel_y;
  assign hit_border_o = res_w.hit;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##Latency done_o) else $error("result beat missing after fixed latency");

  a_hit_whole_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_border_o |-> new_pos_x_o[15:0] == 16'd0 && new_pos_y_o[15:0] == 16'd0)
    else $error("projected position has a fraction");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_border_o |->
      (new_pos_x_o[31:27] == 5'h00 || new_pos_x_o[31:27] == 5'h1f) &&
      (new_pos_y_o[31:27] == 5'h00 || new_pos_y_o[31:27] == 5'h1f))
    else $error("projected position out of playfield range");
`endif

endmodule

`default_nettype wire
